### rtl/s83c_pkg.sv
// Shared constants and types for the 8.3 short name converter.
package s83c_pkg;

   localparam int BASE_LEN  = 8;
   localparam int EXT_LEN   = 3;
   localparam int BYTE_W    = 8;
   localparam int COUNT_W   = 4;
   localparam int BASE_IDX_W = $clog2(BASE_LEN);
   localparam int EXT_IDX_W  = $clog2(EXT_LEN);

   localparam logic [BYTE_W-1:0]  SPACE_CHAR = 8'h20;
   localparam logic [BYTE_W-1:0]  DOT_CHAR   = 8'h2E;
   localparam logic [BYTE_W-1:0]  LOWER_A    = 8'h61;
   localparam logic [BYTE_W-1:0]  LOWER_Z    = 8'h7A;
   localparam logic [BYTE_W-1:0]  UPPER_A    = 8'h41;
   localparam logic [BYTE_W-1:0]  UPPER_Z    = 8'h5A;
   localparam logic [BYTE_W-1:0]  DIGIT_0    = 8'h30;
   localparam logic [BYTE_W-1:0]  DIGIT_9    = 8'h39;
   localparam logic [BYTE_W-1:0]  CASE_DIFF  = 8'h20;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;

   localparam logic [COUNT_W-1:0] BASE_LIMIT = COUNT_W'(BASE_LEN);
   localparam logic [COUNT_W-1:0] EXT_LIMIT  = COUNT_W'(EXT_LEN);

   typedef struct packed {
      logic [BYTE_W-1:0] char_code;
      logic              end_of_name;
   } beat_type;

   typedef struct packed {
      logic                         name_ok;
      logic [BASE_LEN*BYTE_W-1:0]   base_part;
      logic [EXT_LEN*BYTE_W-1:0]    ext_part;
   } result_type;

endpackage

### rtl/s83c_in_stage.sv
// Input register holding one request beat.
module s83c_in_stage
   import s83c_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  beat_type req_beat,
   output logic     req_stall,
   input  logic     advance,
   output logic     in_valid,
   output beat_type in_beat
);

   logic     in_valid_ff, in_valid_in;
   beat_type beat_ff, beat_in;
   logic     load;

   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      beat_in     = beat_ff;
      if (load) begin
         in_valid_in = 1'b1;
         beat_in     = req_beat;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      beat_ff <= beat_in;
   end

   assign in_valid = in_valid_ff;
   assign in_beat  = beat_ff;

endmodule

### rtl/s83c_accum.sv
// Name state: count, dot tracking, reject flag and the 11 name bytes.
module s83c_accum
   import s83c_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  beat_type   beat,
   output result_type result
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               dot_seen_ff, dot_seen_in;
   logic [COUNT_W-1:0] dot_pos_ff, dot_pos_in;
   logic               reject_ff, reject_in;
   logic [BYTE_W-1:0]  base_ff [BASE_LEN];
   logic [BYTE_W-1:0]  base_in [BASE_LEN];
   logic [BYTE_W-1:0]  ext_ff  [EXT_LEN];
   logic [BYTE_W-1:0]  ext_in  [EXT_LEN];

   logic [BYTE_W-1:0]  c;
   logic               is_lower, is_cap, is_digit, is_dot;
   logic [BYTE_W-1:0]  upper_c;
   logic [COUNT_W-1:0] ext_idx;
   logic [COUNT_W:0]   dot_next;
   logic               ok;

   assign c        = beat.char_code;
   assign is_lower = (c >= LOWER_A) && (c <= LOWER_Z);
   assign is_cap   = (c >= UPPER_A) && (c <= UPPER_Z);
   assign is_digit = (c >= DIGIT_0) && (c <= DIGIT_9);
   assign is_dot   = (c == DOT_CHAR);
   assign upper_c  = is_lower ? (c - CASE_DIFF) : c;
   assign ext_idx  = count_ff - dot_pos_ff - COUNT_W'(1);
   assign dot_next = {1'b0, dot_pos_ff} + (COUNT_W+1)'(1);

   // trailing dot: last character was the dot
   assign ok = !reject_ff && (count_ff != '0) &&
               !(dot_seen_ff && ({1'b0, count_ff} == dot_next));

   always_comb begin
      result.name_ok = ok;
      for (int i = 0; i < BASE_LEN; i++) begin
         result.base_part[(BASE_LEN-1-i)*BYTE_W +: BYTE_W] = ok ? base_ff[i] : '0;
      end
      for (int i = 0; i < EXT_LEN; i++) begin
         result.ext_part[(EXT_LEN-1-i)*BYTE_W +: BYTE_W] = ok ? ext_ff[i] : '0;
      end
   end

   always_comb begin
      count_in    = count_ff;
      dot_seen_in = dot_seen_ff;
      dot_pos_in  = dot_pos_ff;
      reject_in   = reject_ff;
      base_in     = base_ff;
      ext_in      = ext_ff;
      if (fire) begin
         if (beat.end_of_name) begin
            count_in    = '0;
            dot_seen_in = 1'b0;
            dot_pos_in  = '0;
            reject_in   = 1'b0;
            for (int i = 0; i < BASE_LEN; i++) base_in[i] = SPACE_CHAR;
            for (int i = 0; i < EXT_LEN; i++)  ext_in[i]  = SPACE_CHAR;
         end else begin
            if (is_dot) begin
               if (dot_seen_ff) begin
                  reject_in = 1'b1;
               end else begin
                  dot_seen_in = 1'b1;
                  dot_pos_in  = count_ff;
               end
            end else if (!(is_lower || is_cap || is_digit)) begin
               reject_in = 1'b1;
            end else if (!dot_seen_ff) begin
               if (count_ff < BASE_LIMIT) begin
                  if (!reject_ff) base_in[count_ff[BASE_IDX_W-1:0]] = upper_c;
               end else begin
                  reject_in = 1'b1;
               end
            end else if (count_ff > dot_pos_ff) begin
               if (ext_idx < EXT_LIMIT) begin
                  if (!reject_ff) ext_in[ext_idx[EXT_IDX_W-1:0]] = upper_c;
               end else begin
                  reject_in = 1'b1;
               end
            end else begin
               reject_in = 1'b1;
            end
            if (count_ff != COUNT_MAX) count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         dot_seen_ff <= 1'b0;
         dot_pos_ff  <= '0;
         reject_ff   <= 1'b0;
         for (int i = 0; i < BASE_LEN; i++) base_ff[i] <= SPACE_CHAR;
         for (int i = 0; i < EXT_LEN; i++)  ext_ff[i]  <= SPACE_CHAR;
      end else begin
         count_ff    <= count_in;
         dot_seen_ff <= dot_seen_in;
         dot_pos_ff  <= dot_pos_in;
         reject_ff   <= reject_in;
         base_ff     <= base_in;
         ext_ff      <= ext_in;
      end
   end

endmodule

### rtl/s83c_out_stage.sv
// Result register on the response side.
module s83c_out_stage
   import s83c_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       out_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_result
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff, result_in;

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   assign result_in    = load ? result : result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule

### rtl/short_name_8_3_converter.sv
// Top level of the 8.3 short name converter.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_char_code[7:0], req_end_of_name
//   rsp      out        rsp_valid / rsp_stall  rsp_name_ok, rsp_base_part[63:0],
//                                              rsp_ext_part[23:0]
//
// One beat per cycle is taken while req_stall is low. A beat is captured in
// the input register; as it leaves, a character beat updates the name state
// and an end beat loads the result register, from which the result is taken.
// Reset clears the name to all spaces and empties both registers.
// An end beat waits in the input register while a result is stalled;
// character beats keep flowing past a stalled result.
module short_name_8_3_converter
   import s83c_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [BYTE_W-1:0]          req_char_code,
   input  logic                       req_end_of_name,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_name_ok,
   output logic [BASE_LEN*BYTE_W-1:0] rsp_base_part,
   output logic [EXT_LEN*BYTE_W-1:0]  rsp_ext_part
);

   beat_type   req_beat, in_beat;
   logic       in_valid, advance, out_ready, result_load;
   result_type result, rsp_result;

   assign req_beat.char_code   = req_char_code;
   assign req_beat.end_of_name = req_end_of_name;

   assign advance     = in_valid && (!in_beat.end_of_name || out_ready);
   assign result_load = advance && in_beat.end_of_name;

   s83c_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_beat  (req_beat),
      .req_stall (req_stall),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_beat   (in_beat)
   );

   s83c_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .beat   (in_beat),
      .result (result)
   );

   s83c_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (result_load),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_name_ok   = rsp_result.name_ok;
   assign rsp_base_part = rsp_result.base_part;
   assign rsp_ext_part  = rsp_result.ext_part;

endmodule
